// File: hw/rtl/particle_table_update_defines.svh
// Assertion helpers for the particle table.
`ifndef PARTICLE_TABLE_UPDATE_DEFINES_SVH
`define PARTICLE_TABLE_UPDATE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PTU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PTU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/ptu_pkg.sv
`default_nettype none
package ptu_pkg;

  localparam int MAX_PARTICLES_DEF = 64;

  // command codes
  localparam logic [1:0] CMD_EMIT   = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_DRAW   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_RECORD  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [1:0] KIND_DROPPED = 2'd2;

  // angle step per ms, Q0.24 turn
  localparam logic [23:0] ANGLE_PER_MS = 24'd134;
  // reciprocal of 1000 for 32-bit operands, used with a right shift of 38
  localparam logic [28:0] RECIP_1000 = 29'd274877907;
  localparam int RECIP_SHIFT = 38;
  localparam logic [31:0] ROUND_999 = 32'd999;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] position_xy;
    logic [31:0] velocity_xy;
    logic [31:0] velocity_spread_xy;
    logic [63:0] color_pair;
    logic [35:0] size_triple;
    logic [15:0] time_ms;
    logic [63:0] random_bits;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic [11:0]        side_len;
    logic [31:0]        rgba;
    logic [15:0]        angle_out;
    logic               last;
  } out_item_t;

  // one table entry
  typedef struct packed {
    logic [31:0]        pos;
    logic [31:0]        vel;
    logic [63:0]        color;
    logic [23:0]        size;
    logic [15:0]        life;
    logic signed [16:0] remain;
    logic [23:0]        angle;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EM1,
    ST_EM2,
    ST_STAT,
    ST_TRD,
    ST_TCHK,
    ST_TX2,
    ST_TY1,
    ST_TY2,
    ST_TWR,
    ST_DRD,
    ST_DPREP,
    ST_DLV,
    ST_DDIV,
    ST_DOUT
  } state_t;

  // saturate to the signed 16-bit range
  function automatic logic signed [15:0] sat16(input logic signed [24:0] v);
    logic signed [15:0] r;
    if (v > 25'sd32767)       r = 16'sh7FFF;
    else if (v < -25'sd32768) r = -16'sh8000;
    else                      r = v[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/particle_table_update.sv
// Particle table. Each command is one input item; the block takes one item at a
// time and stalls its input until that item's work is done. Emit writes one new entry
// (none when the table is full) and gives one status item. Tick visits each entry,
// drops the expired ones and rewrites each survivor in a read-modify-write pass
// through the entry memory and the shared multiplier pair (velocity times dt,
// then the reciprocal of 1000). Draw reads each particle and gives one record,
// using the serial divider that does 12 steps for each of the five lerps (four
// color channels and size), and waits while the output is stalled. No clearing
// pass is needed after reset.
`default_nettype none
`include "particle_table_update_defines.svh"
module particle_table_update
  import ptu_pkg::*;
#(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int IW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_PARTICLES);

  // entry memory
  entry_t mem [MAX_PARTICLES];
  entry_t rd_r;
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_r <= mem[mem_raddr];
  end

  // control registers
  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] w_r, w_nxt;
  logic          out_valid_r, out_valid_nxt;

  // payload registers
  in_item_t           in_r, in_nxt;
  logic signed [32:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [28:0] ps_r, ps_nxt;
  logic signed [32:0] prod_r, prod_nxt;
  logic [60:0]        recip_r, recip_nxt;
  logic               neg_r, neg_nxt;
  logic signed [15:0] newx_r, newx_nxt;
  logic [15:0]        num_r, num_nxt, den_r, den_nxt;
  logic [2:0]         ch_r, ch_nxt;
  logic [11:0]        vsh_r, vsh_nxt;
  logic [15:0]        rem_r, rem_nxt;
  logic [11:0]        q_r, q_nxt;
  logic [3:0]         bit_r, bit_nxt;
  logic [31:0]        rgba_r, rgba_nxt;
  logic [11:0]        side_r, side_nxt;
  logic [1:0]         kind_r, kind_nxt;
  out_item_t          out_r, out_nxt;
  logic               out_load;

  logic out_free;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // shared working terms
  logic signed [15:0] dx, dy, ds;
  logic signed [17:0] vx_w, vy_w;
  logic signed [13:0] sb_w;
  logic [11:0]        sb_sat;
  logic [31:0]        abs_a;
  logic signed [24:0] q_w, sum_w;
  logic signed [17:0] diff_w;
  logic [11:0]        s_w, e_w;
  logic signed [30:0] v_w;
  logic [16:0]        trial_w;
  logic [11:0]        qf_w;
  logic [15:0]        dt_w;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    i_nxt         = i_r;
    w_nxt         = w_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_nxt        = in_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    ps_nxt        = ps_r;
    prod_nxt      = prod_r;
    recip_nxt     = recip_r;
    neg_nxt       = neg_r;
    newx_nxt      = newx_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    ch_nxt        = ch_r;
    vsh_nxt       = vsh_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    bit_nxt       = bit_r;
    rgba_nxt      = rgba_r;
    side_nxt      = side_r;
    kind_nxt      = kind_r;
    out_nxt       = out_r;
    out_load      = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = w_r[IW-1:0];
    mem_raddr     = i_r[IW-1:0];
    mem_wdata     = rd_r;
    dt_w          = in_r.time_ms;

    // random fraction minus one half: flip the top bit
    dx = {~in_r.random_bits[47], in_r.random_bits[46:32]};
    dy = {~in_r.random_bits[31], in_r.random_bits[30:16]};
    ds = {~in_r.random_bits[15], in_r.random_bits[14:0]};
    vx_w = 18'($signed(in_r.velocity_xy[31:16])) + 18'(px_r >>> 16);
    vy_w = 18'($signed(in_r.velocity_xy[15:0])) + 18'(py_r >>> 16);
    sb_w = $signed({2'b00, in_r.size_triple[35:24]}) + 14'(ps_r >>> 16);
    if (sb_w < 14'sd0)         sb_sat = 12'd0;
    else if (sb_w > 14'sd4095) sb_sat = 12'hFFF;
    else                       sb_sat = sb_w[11:0];

    // floor(prod/1000) via reciprocal on the magnitude
    abs_a = prod_r[32] ? 32'(-prod_r) + ROUND_999 : prod_r[31:0];
    q_w   = neg_r ? -$signed({2'b00, recip_r[60:RECIP_SHIFT]})
                  : $signed({2'b00, recip_r[60:RECIP_SHIFT]});
    sum_w = 25'(q_w) + 25'(neg_r ? 25'sd0 : 25'sd0);

    // age numerator
    diff_w = $signed({2'b00, rd_r.life}) - 18'(rd_r.remain);

    // lerp operands by channel
    case (ch_r)
      3'd0: begin s_w = {4'd0, rd_r.color[63:56]}; e_w = {4'd0, rd_r.color[31:24]}; end
      3'd1: begin s_w = {4'd0, rd_r.color[55:48]}; e_w = {4'd0, rd_r.color[23:16]}; end
      3'd2: begin s_w = {4'd0, rd_r.color[47:40]}; e_w = {4'd0, rd_r.color[15:8]}; end
      3'd3: begin s_w = {4'd0, rd_r.color[39:32]}; e_w = {4'd0, rd_r.color[7:0]}; end
      default: begin s_w = rd_r.size[23:12]; e_w = rd_r.size[11:0]; end
    endcase
    v_w = $signed({3'b000, 28'(s_w * den_r)})
        + 31'(($signed({1'b0, e_w}) - $signed({1'b0, s_w})) * $signed({1'b0, num_r}));

    // one restoring division step
    trial_w = {rem_r, vsh_r[11]};
    qf_w    = {q_r[10:0], (trial_w >= {1'b0, den_r})};

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          in_nxt = in_data;
          case (in_data.cmd)
            CMD_EMIT: begin
              if (count_r == COUNT_MAX) begin
                kind_nxt  = KIND_DROPPED;
                state_nxt = ST_STAT;
              end else begin
                state_nxt = ST_EM1;
              end
            end
            CMD_TICK: begin
              i_nxt     = '0;
              w_nxt     = '0;
              state_nxt = ST_TRD;
            end
            CMD_DRAW: begin
              i_nxt = '0;
              if (count_r != '0) state_nxt = ST_DRD;
            end
            default: ;
          endcase
        end
      end

      // emit: spread products, then write the new entry
      ST_EM1: begin
        px_nxt = $signed({1'b0, in_r.velocity_spread_xy[31:16]}) * dx;
        py_nxt = $signed({1'b0, in_r.velocity_spread_xy[15:0]}) * dy;
        ps_nxt = 29'($signed({1'b0, in_r.size_triple[11:0]}) * ds);
        state_nxt = ST_EM2;
      end
      ST_EM2: begin
        mem_we    = 1'b1;
        mem_waddr = count_r[IW-1:0];
        mem_wdata.pos    = in_r.position_xy;
        mem_wdata.vel    = {sat16(25'(vx_w)), sat16(25'(vy_w))};
        mem_wdata.color  = in_r.color_pair;
        mem_wdata.size   = {sb_sat, in_r.size_triple[23:12]};
        mem_wdata.life   = in_r.time_ms;
        mem_wdata.remain = $signed({1'b0, in_r.time_ms});
        mem_wdata.angle  = {in_r.random_bits[63:48], 8'd0};
        count_nxt = count_r + 1'b1;
        kind_nxt  = KIND_ACCEPT;
        state_nxt = ST_STAT;
      end
      // status item waits here until the output register is free
      ST_STAT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          out_nxt.kind  = kind_r;
          out_nxt.last  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      // tick: walk entries, compact survivors down to w
      ST_TRD: begin
        if (i_r == count_r) begin
          count_nxt = w_r;
          state_nxt = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          state_nxt = ST_TCHK;
        end
      end
      ST_TCHK: begin
        if (rd_r.remain <= 17'sd0) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_TRD;
        end else begin
          prod_nxt  = $signed(rd_r.vel[31:16]) * $signed({1'b0, dt_w});
          state_nxt = ST_TX2;
        end
      end
      ST_TX2, ST_TY2: begin
        recip_nxt = abs_a * RECIP_1000;
        neg_nxt   = prod_r[32];
        state_nxt = (state_r == ST_TX2) ? ST_TY1 : ST_TWR;
      end
      ST_TY1: begin
        newx_nxt  = sat16($signed({{9{rd_r.pos[31]}}, rd_r.pos[31:16]}) + sum_w);
        prod_nxt  = $signed(rd_r.vel[15:0]) * $signed({1'b0, dt_w});
        state_nxt = ST_TY2;
      end
      ST_TWR: begin
        mem_we    = 1'b1;
        mem_wdata.pos    = {newx_r,
                            sat16($signed({{9{rd_r.pos[15]}}, rd_r.pos[15:0]}) + sum_w)};
        mem_wdata.remain = rd_r.remain - $signed({1'b0, dt_w});
        mem_wdata.angle  = rd_r.angle + 24'({8'd0, dt_w} * ANGLE_PER_MS);
        w_nxt     = w_r + 1'b1;
        i_nxt     = i_r + 1'b1;
        state_nxt = ST_TRD;
      end

      // draw: read entry, five serial lerps, one record
      ST_DRD: begin
        mem_re    = 1'b1;
        state_nxt = ST_DPREP;
      end
      ST_DPREP: begin
        if (rd_r.life == 16'd0) begin
          num_nxt = 16'd1;
          den_nxt = 16'd1;
        end else begin
          den_nxt = rd_r.life;
          if (diff_w < 18'sd0)                         num_nxt = 16'd0;
          else if (diff_w > $signed({2'b00, rd_r.life})) num_nxt = rd_r.life;
          else                                          num_nxt = diff_w[15:0];
        end
        ch_nxt    = 3'd0;
        state_nxt = ST_DLV;
      end
      ST_DLV: begin
        // quotient fits 12 bits, so the upper part is already below den
        rem_nxt   = v_w[27:12];
        vsh_nxt   = v_w[11:0];
        q_nxt     = '0;
        bit_nxt   = 4'd11;
        state_nxt = ST_DDIV;
      end
      ST_DDIV: begin
        rem_nxt = (trial_w >= {1'b0, den_r}) ? 16'(trial_w - {1'b0, den_r}) : trial_w[15:0];
        vsh_nxt = {vsh_r[10:0], 1'b0};
        q_nxt   = qf_w;
        bit_nxt = bit_r - 1'b1;
        if (bit_r == 4'd0) begin
          case (ch_r)
            3'd0:    rgba_nxt[31:24] = qf_w[7:0];
            3'd1:    rgba_nxt[23:16] = qf_w[7:0];
            3'd2:    rgba_nxt[15:8]  = qf_w[7:0];
            3'd3:    rgba_nxt[7:0]   = qf_w[7:0];
            default: side_nxt        = qf_w;
          endcase
          ch_nxt    = ch_r + 1'b1;
          state_nxt = (ch_r == 3'd4) ? ST_DOUT : ST_DLV;
        end
      end
      ST_DOUT: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_valid_nxt     = 1'b1;
          out_nxt.kind      = KIND_RECORD;
          out_nxt.x_pos     = rd_r.pos[31:16];
          out_nxt.y_pos     = rd_r.pos[15:0];
          out_nxt.side_len  = side_r;
          out_nxt.rgba      = rgba_r;
          out_nxt.angle_out = rd_r.angle[23:8];
          out_nxt.last      = (i_r + 1'b1 == count_r);
          i_nxt             = i_r + 1'b1;
          state_nxt         = (i_r + 1'b1 == count_r) ? ST_IDLE : ST_DRD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      i_r         <= '0;
      w_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      i_r         <= i_nxt;
      w_r         <= w_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    in_r    <= in_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    ps_r    <= ps_nxt;
    prod_r  <= prod_nxt;
    recip_r <= recip_nxt;
    neg_r   <= neg_nxt;
    newx_r  <= newx_nxt;
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    ch_r    <= ch_nxt;
    vsh_r   <= vsh_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    bit_r   <= bit_nxt;
    rgba_r  <= rgba_nxt;
    side_r  <= side_nxt;
    kind_r  <= kind_nxt;
    if (out_load) out_r <= out_nxt;
  end

  `PTU_ASSERT_NOW(a_count_bound, 1'b1, count_r <= COUNT_MAX, "live count above table depth")
  `PTU_ASSERT_NOW(a_compact_order, state_r == ST_TWR, w_r <= i_r, "tick write ahead of read")
  `PTU_ASSERT_NOW(a_out_load_free, out_load, out_free, "result loaded over a waiting item")

endmodule
`default_nettype wire
